// File: rtl/pptkf_pkg.sv
// Package with the shared types, constants and keyword tables of the PUBLISH topic filter.
package pptkf_pkg;

   // Packet limits.
   localparam int PAYLOAD_BUFFER = 160;
   localparam int TOPIC_BUFFER   = 64;
   localparam int MIN_PACKET     = 5;
   localparam int TOPIC_MAX      = 48;

   // Derived widths.
   localparam int TOPIC_LEN_W = $clog2(TOPIC_BUFFER);
   localparam int TOPIC_IDX_W = TOPIC_LEN_W + 1;
   localparam int PAY_CNT_W   = $clog2(PAYLOAD_BUFFER);
   localparam int BYTE_CNT_W  = $clog2(MIN_PACKET + 1);
   localparam int TOPIC_REGS  = TOPIC_MAX / 8;

   // Header type nibble of a PUBLISH packet.
   localparam logic [3:0] PUBLISH_TYPE = 4'h3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TOPIC_LENGTH  = 3'd0;
   localparam logic [2:0] CSR_TOPIC_CHARS_0 = 3'd1;
   localparam logic [2:0] CSR_TOPIC_CHARS_1 = 3'd2;
   localparam logic [2:0] CSR_TOPIC_CHARS_2 = 3'd3;
   localparam logic [2:0] CSR_TOPIC_CHARS_3 = 3'd4;
   localparam logic [2:0] CSR_TOPIC_CHARS_4 = 3'd5;
   localparam logic [2:0] CSR_TOPIC_CHARS_5 = 3'd6;

   // Event codes.
   localparam logic [1:0] EVENT_NONE  = 2'd0;
   localparam logic [1:0] EVENT_WIN   = 2'd1;
   localparam logic [1:0] EVENT_LOSE  = 2'd2;
   localparam logic [1:0] EVENT_RESET = 2'd3;

   // Keyword window: one cell per byte, oldest byte in cell zero.
   localparam int WINDOW     = 21;
   localparam int CELL_IDX_W = $clog2(WINDOW);
   localparam int KW_COUNT   = 6;

   // Keywords right-aligned so that the last character sits in the newest cell.
   localparam logic [WINDOW*8-1:0] KW_TEXT [KW_COUNT] = '{
      "\"result\":\"win\"",
      "\"result\":\"lose\"",
      "\"result\":\"reset\"",
      "\"result\":\"exit\"",
      "\"status\":\"offline\"",
      "\"status\":\"disconnect\""
   };
   localparam int KW_LEN [KW_COUNT] = '{14, 15, 16, 15, 18, 21};

   // Input and result transactions.
   typedef struct packed {
      logic [7:0] packet_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] event_code;
      logic       exit_seen;
      logic       packet_accepted;
   } rsp_type;

   // Control shared by all window cells.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

// File: rtl/pptkf_window_cell.sv
// One cell of the keyword window: holds a byte and matches its incoming byte against the keywords.
module pptkf_window_cell
   import pptkf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CELL_IDX_W-1:0] cell_index,
   input  cell_ctrl_type         ctrl,
   input  logic [7:0]            shift_in,
   output logic [7:0]            held_out,
   output logic [KW_COUNT-1:0]   match_out
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // The byte moves in from the neighbor on a shift; a packet end clears the cell.
   always_comb begin
      data_in = data_ff;
      if (ctrl.clear) begin
         data_in = 8'h00;
      end else if (ctrl.shift) begin
         data_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= 8'h00;
      end else begin
         data_ff <= data_in;
      end
   end

   assign held_out = data_ff;

   // A cell in front of a keyword's first character does not constrain that keyword.
   always_comb begin
      int pos;
      int lsb;
      pos = int'(cell_index);
      lsb = (WINDOW - 1 - pos) * 8;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (pos < WINDOW - KW_LEN[k]) begin
            match_out[k] = 1'b1;
         end else begin
            match_out[k] = (shift_in == KW_TEXT[k][lsb +: 8]);
         end
      end
   end

endmodule

// File: rtl/publish_packet_topic_keyword_filter.sv
// Top level of the PUBLISH topic and keyword filter: byte parser, window chain and result register.
//
// The filter takes one packet byte per clock cycle while req_stall is low, and gives one
// verdict transaction in the cycle after the byte that carries final_byte; other bytes give
// none. The header, remaining-length and topic checks are a small phase machine, and the
// payload passes through a chain of 21 byte cells that shift once per payload byte, up to a
// zero byte or the size limit, and compare their contents with six quoted keywords in that
// same cycle. A verdict waits in the result register while rsp_stall is high; only then, and
// only once a second verdict would be due, is req_stall raised. Configuration writes are
// always ready and should be made while no packet is in progress.
module publish_packet_topic_keyword_filter
   import pptkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_REMLEN,
      PH_TLHI,
      PH_TLLO,
      PH_TOPIC,
      PH_PAYLOAD,
      PH_REJECT
   } phase_type;

   // Registers.
   phase_type               phase_ff, phase_in;
   logic [BYTE_CNT_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic                    len_hi_ff, len_hi_in;
   logic [TOPIC_LEN_W-1:0]  rx_len_ff, rx_len_in;
   logic [TOPIC_LEN_W-1:0]  topic_idx_ff, topic_idx_in;
   logic                    mismatch_ff, mismatch_in;
   logic                    zero_seen_ff, zero_seen_in;
   logic [PAY_CNT_W-1:0]    pay_cnt_ff, pay_cnt_in;
   logic                    stopped_ff, stopped_in;
   logic [KW_COUNT-1:0]     hits_ff, hits_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [TOPIC_LEN_W-1:0]  topic_length_ff, topic_length_in;
   logic [TOPIC_MAX*8-1:0]  topic_flat_ff, topic_flat_in;

   logic                    accept;
   logic [7:0]              b;
   cell_ctrl_type           cell_ctrl;
   logic [7:0]              cell_data  [WINDOW];
   logic [KW_COUNT-1:0]     cell_match [WINDOW];
   logic [KW_COUNT-1:0]     hit_now;

   assign b         = req_payload.packet_byte;
   assign accept    = req_valid && !req_stall;
   // Only a last byte has to wait for the result register to free up.
   assign req_stall = rsp_valid_ff && rsp_stall && req_payload.final_byte;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Expected topic byte at an index; zero past the configured length or the topic store.
   function automatic logic [7:0] expected_byte(input logic [TOPIC_IDX_W-1:0] i,
                                                input logic [TOPIC_LEN_W-1:0] len,
                                                input logic [TOPIC_MAX*8-1:0] chars);
      logic [7:0] r;
      r = 8'h00;
      if ((i < TOPIC_IDX_W'(TOPIC_MAX)) && (i < {1'b0, len})) begin
         r = chars[{i[TOPIC_LEN_W-1:0], 3'b000} +: 8];
      end
      return r;
   endfunction

   // Window chain: the newest byte enters the last cell, the others take their neighbor's.
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      logic [7:0] feed;
      if (i == WINDOW - 1) begin : g_last
         assign feed = b;
      end else begin : g_mid
         assign feed = cell_data[i+1];
      end
      pptkf_window_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CELL_IDX_W'(i)),
         .ctrl       (cell_ctrl),
         .shift_in   (feed),
         .held_out   (cell_data[i]),
         .match_out  (cell_match[i])
      );
   end

   // A keyword is found when every cell agrees after the shift.
   always_comb begin
      hit_now = '1;
      for (int i = 0; i < WINDOW; i++) begin
         hit_now = hit_now & cell_match[i];
      end
   end

   // Configuration writes.
   always_comb begin
      topic_length_in = topic_length_ff;
      topic_flat_in   = topic_flat_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TOPIC_LENGTH:  topic_length_in = csr_data[TOPIC_LEN_W-1:0];
            CSR_TOPIC_CHARS_0: topic_flat_in[0*64 +: 64] = csr_data;
            CSR_TOPIC_CHARS_1: topic_flat_in[1*64 +: 64] = csr_data;
            CSR_TOPIC_CHARS_2: topic_flat_in[2*64 +: 64] = csr_data;
            CSR_TOPIC_CHARS_3: topic_flat_in[3*64 +: 64] = csr_data;
            CSR_TOPIC_CHARS_4: topic_flat_in[4*64 +: 64] = csr_data;
            CSR_TOPIC_CHARS_5: topic_flat_in[5*64 +: 64] = csr_data;
            default: ;
         endcase
      end
   end

   // Byte parser, verdict and result register.
   always_comb begin
      logic [TOPIC_IDX_W-1:0] idx_next;
      logic                   mis_step;
      logic                   zs_step;
      logic                   ok;
      logic                   ex;
      logic [1:0]             ev;

      phase_in     = phase_ff;
      byte_cnt_in  = byte_cnt_ff;
      len_hi_in    = len_hi_ff;
      rx_len_in    = rx_len_ff;
      topic_idx_in = topic_idx_ff;
      mismatch_in  = mismatch_ff;
      zero_seen_in = zero_seen_ff;
      pay_cnt_in   = pay_cnt_ff;
      stopped_in   = stopped_ff;
      hits_in      = hits_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_ctrl    = '0;
      idx_next     = {1'b0, topic_idx_ff} + 1'b1;
      mis_step     = mismatch_ff || (!zero_seen_ff &&
                     (b != expected_byte({1'b0, topic_idx_ff}, topic_length_ff,
                                         topic_flat_ff)));
      zs_step      = zero_seen_ff || (b == 8'h00);
      ok           = 1'b0;
      ex           = 1'b0;
      ev           = EVENT_NONE;

      if (accept) begin
         if (byte_cnt_ff != BYTE_CNT_W'(MIN_PACKET)) begin
            byte_cnt_in = byte_cnt_ff + 1'b1;
         end

         case (phase_ff)
            PH_HEAD: begin
               phase_in = (b[7:4] == PUBLISH_TYPE) ? PH_REMLEN : PH_REJECT;
            end
            PH_REMLEN: begin
               if (!b[7]) begin
                  phase_in = PH_TLHI;
               end
            end
            PH_TLHI: begin
               len_hi_in = (b != 8'h00);
               phase_in  = PH_TLLO;
            end
            PH_TLLO: begin
               rx_len_in = b[TOPIC_LEN_W-1:0];
               if (len_hi_ff || ({1'b0, b} >= 9'(TOPIC_BUFFER))) begin
                  phase_in = PH_REJECT;
               end else if (b == 8'h00) begin
                  // An empty topic matches only an empty expected topic.
                  phase_in = (expected_byte('0, topic_length_ff, topic_flat_ff) != 8'h00) ?
                             PH_REJECT : PH_PAYLOAD;
               end else begin
                  phase_in = PH_TOPIC;
               end
            end
            PH_TOPIC: begin
               // Bytes after a zero byte in the topic are not compared.
               mismatch_in  = mis_step;
               zero_seen_in = zs_step;
               topic_idx_in = idx_next[TOPIC_LEN_W-1:0];
               if (idx_next >= {1'b0, rx_len_ff}) begin
                  mismatch_in = mis_step || (!zs_step &&
                     (expected_byte(idx_next, topic_length_ff, topic_flat_ff) != 8'h00));
                  phase_in = mismatch_in ? PH_REJECT : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (!stopped_ff && (pay_cnt_ff < PAY_CNT_W'(PAYLOAD_BUFFER - 1))) begin
                  if (b == 8'h00) begin
                     stopped_in = 1'b1;
                  end else begin
                     cell_ctrl.shift = 1'b1;
                     pay_cnt_in      = pay_cnt_ff + 1'b1;
                     hits_in         = hits_ff | hit_now;
                  end
               end
            end
            default: ;
         endcase

         if (req_payload.final_byte) begin
            ok = (phase_in == PH_PAYLOAD) && (byte_cnt_in == BYTE_CNT_W'(MIN_PACKET));
            if (ok) begin
               ex = |hits_in[5:3];
               if (hits_in[0]) begin
                  ev = EVENT_WIN;
               end else if (hits_in[1]) begin
                  ev = EVENT_LOSE;
               end else if (hits_in[2] || ex) begin
                  ev = EVENT_RESET;
               end
            end
            rsp_in.event_code      = ev;
            rsp_in.exit_seen       = ex;
            rsp_in.packet_accepted = ok;
            rsp_valid_in           = 1'b1;

            // Ready for the next packet.
            cell_ctrl.clear = 1'b1;
            phase_in     = PH_HEAD;
            byte_cnt_in  = '0;
            len_hi_in    = 1'b0;
            rx_len_in    = '0;
            topic_idx_in = '0;
            mismatch_in  = 1'b0;
            zero_seen_in = 1'b0;
            pay_cnt_in   = '0;
            stopped_in   = 1'b0;
            hits_in      = '0;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEAD;
         byte_cnt_ff     <= '0;
         len_hi_ff       <= 1'b0;
         rx_len_ff       <= '0;
         topic_idx_ff    <= '0;
         mismatch_ff     <= 1'b0;
         zero_seen_ff    <= 1'b0;
         pay_cnt_ff      <= '0;
         stopped_ff      <= 1'b0;
         hits_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         topic_length_ff <= '0;
         topic_flat_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         byte_cnt_ff     <= byte_cnt_in;
         len_hi_ff       <= len_hi_in;
         rx_len_ff       <= rx_len_in;
         topic_idx_ff    <= topic_idx_in;
         mismatch_ff     <= mismatch_in;
         zero_seen_ff    <= zero_seen_in;
         pay_cnt_ff      <= pay_cnt_in;
         stopped_ff      <= stopped_in;
         hits_ff         <= hits_in;
         rsp_valid_ff    <= rsp_valid_in;
         topic_length_ff <= topic_length_in;
         topic_flat_ff   <= topic_flat_in;
      end
      rsp_ff <= rsp_in;
   end

`ifndef SYNTH
   // A last byte always produces a verdict in the next cycle.
   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.final_byte) |=> rsp_valid_ff)
      else $error("no verdict after the last byte of a packet");

   // The parser starts the next packet from a clean state.
   a_packet_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.final_byte) |=>
         (phase_ff == PH_HEAD) && (hits_ff == '0) && (pay_cnt_ff == '0))
      else $error("packet state not cleared after a verdict");

   // A rejected packet carries no event and no exit flag.
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.packet_accepted) |->
         (rsp_ff.event_code == EVENT_NONE) && !rsp_ff.exit_seen)
      else $error("rejected packet reports an event");

   // An exit keyword always raises some event.
   a_exit_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.exit_seen) |-> (rsp_ff.event_code != EVENT_NONE))
      else $error("exit seen without an event");
`endif

endmodule

// File: tb/sv/publish_filter_checker.sv
// Checker for the PUBLISH topic filter: predicts every verdict and compares it with the block.
`timescale 1ns / 100ps
module publish_filter_checker
   import pptkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_payload,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          mismatch_count,
   output int          pending_count,
   output int          verdict_count,
   output int          accepted_count,
   output int          event_count
);

   // Parser position within a packet.
   typedef enum logic [2:0] {
      AT_HEADER,
      AT_REMAINING,
      AT_LENGTH_HI,
      AT_LENGTH_LO,
      AT_TOPIC,
      AT_PAYLOAD,
      AT_REJECT
   } parse_phase_type;

   // Bit positions of the keyword hits.
   localparam int HIT_WIN        = 0;
   localparam int HIT_LOSE       = 1;
   localparam int HIT_RESET      = 2;
   localparam int HIT_EXIT       = 3;
   localparam int HIT_OFFLINE    = 4;
   localparam int HIT_DISCONNECT = 5;

   // Copy of the configuration registers.
   logic [5:0]  topic_size_reg;
   logic [63:0] topic_word [TOPIC_REGS];

   // Copy of the parser state.
   parse_phase_type     phase;
   logic [15:0]         byte_total;
   logic [15:0]         topic_size_rx;
   logic [15:0]         topic_pos;
   logic                topic_bad;
   logic                topic_ended;
   int                  payload_seen;
   logic                payload_done;
   logic [7:0]          tail_bytes [WINDOW];
   logic [KW_COUNT-1:0] found;

   rsp_type verdict_queue [$];
   int      errors   = 0;
   int      verdicts = 0;
   int      accepted = 0;
   int      events   = 0;

   // Quoted keywords, in the order of the hit bits.
   function automatic string keyword(int k);
      case (k)
         HIT_WIN:     return "\"result\":\"win\"";
         HIT_LOSE:    return "\"result\":\"lose\"";
         HIT_RESET:   return "\"result\":\"reset\"";
         HIT_EXIT:    return "\"result\":\"exit\"";
         HIT_OFFLINE: return "\"status\":\"offline\"";
         default:     return "\"status\":\"disconnect\"";
      endcase
   endfunction

   // Expected topic byte; bytes past the register space read as zero.
   function automatic logic [7:0] topic_char(int i);
      if (i >= TOPIC_MAX) return 8'h00;
      return topic_word[i / 8][(i % 8) * 8 +: 8];
   endfunction

   // Length of the expected topic: the register value, capped and cut at a zero byte.
   function automatic int topic_want();
      int lim;
      lim = (topic_size_reg > TOPIC_MAX) ? TOPIC_MAX : int'(topic_size_reg);
      for (int i = 0; i < lim; i++) begin
         if (topic_char(i) == 8'h00) return i;
      end
      return lim;
   endfunction

   function automatic void clear_parse();
      phase         = AT_HEADER;
      byte_total    = '0;
      topic_size_rx = '0;
      topic_pos     = '0;
      topic_bad     = 1'b0;
      topic_ended   = 1'b0;
      payload_seen  = 0;
      payload_done  = 1'b0;
      found         = '0;
      for (int i = 0; i < WINDOW; i++) tail_bytes[i] = 8'h00;
   endfunction

   // The whole topic has been read: decide whether the payload is searched.
   function automatic void end_topic();
      if (!topic_ended && topic_size_rx != topic_want()) topic_bad = 1'b1;
      phase = topic_bad ? AT_REJECT : AT_PAYLOAD;
   endfunction

   function automatic logic tail_is(string kw);
      int   n;
      logic hit;
      n   = kw.len();
      hit = 1'b1;
      for (int j = 0; j < n; j++) begin
         if (tail_bytes[WINDOW - n + j] != kw[j]) hit = 1'b0;
      end
      return hit;
   endfunction

   // Payload bytes shift into the window until a zero byte or the size limit.
   function automatic void take_payload(logic [7:0] b);
      if (payload_done || payload_seen >= PAYLOAD_BUFFER - 1) return;
      if (b == 8'h00) begin
         payload_done = 1'b1;
         return;
      end
      for (int i = 0; i < WINDOW - 1; i++) tail_bytes[i] = tail_bytes[i + 1];
      tail_bytes[WINDOW - 1] = b;
      payload_seen++;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (tail_is(keyword(k))) found[k] = 1'b1;
      end
   endfunction

   // Topic bytes are compared up to the first zero byte of the received topic.
   function automatic void take_topic(logic [7:0] b);
      int el;
      el = topic_want();
      if (!topic_ended) begin
         if (b == 8'h00) begin
            topic_ended = 1'b1;
            if (topic_pos != el) topic_bad = 1'b1;
         end else if (topic_pos >= el || b != topic_char(int'(topic_pos))) begin
            topic_bad = 1'b1;
         end
      end
      topic_pos++;
      if (topic_pos >= topic_size_rx) end_topic();
   endfunction

   // Advance the parser by one byte; the last byte of a packet yields a verdict.
   function automatic void parse_packet_byte(logic [7:0] b, logic last);
      rsp_type v;
      if (byte_total != 16'hFFFF) byte_total++;
      case (phase)
         AT_HEADER: begin
            phase = (b[7:4] == PUBLISH_TYPE) ? AT_REMAINING : AT_REJECT;
         end
         AT_REMAINING: begin
            if (!b[7]) phase = AT_LENGTH_HI;
         end
         AT_LENGTH_HI: begin
            topic_size_rx = {b, 8'h00};
            phase         = AT_LENGTH_LO;
         end
         AT_LENGTH_LO: begin
            topic_size_rx = topic_size_rx | {8'h00, b};
            if (topic_size_rx >= TOPIC_BUFFER) phase = AT_REJECT;
            else if (topic_size_rx == 16'd0) end_topic();
            else phase = AT_TOPIC;
         end
         AT_TOPIC:   take_topic(b);
         AT_PAYLOAD: take_payload(b);
         default: ;
      endcase
      if (last) begin
         v = '0;
         if (phase == AT_PAYLOAD && byte_total >= MIN_PACKET) begin
            v.packet_accepted = 1'b1;
            v.exit_seen = found[HIT_EXIT] | found[HIT_OFFLINE] | found[HIT_DISCONNECT];
            if (found[HIT_WIN]) v.event_code = EVENT_WIN;
            else if (found[HIT_LOSE]) v.event_code = EVENT_LOSE;
            else if (found[HIT_RESET] || v.exit_seen) v.event_code = EVENT_RESET;
            else v.event_code = EVENT_NONE;
         end
         verdict_queue.push_back(v);
         clear_parse();
      end
   endfunction

   task automatic report(string what, rsp_type want, rsp_type got);
      errors++;
      if (errors <= 10) begin
         $display("verdict error at %0t (%s): expected event %0d exit %0b accepted %0b,",
                  $realtime, what, want.event_code, want.exit_seen, want.packet_accepted);
         $display("   got event %0d exit %0b accepted %0b",
                  got.event_code, got.exit_seen, got.packet_accepted);
      end
   endtask

   // Watch the three channels; results are checked before the byte of the same edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         topic_size_reg = '0;
         for (int k = 0; k < TOPIC_REGS; k++) topic_word[k] = '0;
         clear_parse();
         verdict_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TOPIC_LENGTH) begin
               topic_size_reg = csr_data[5:0];
            end else if (csr_index >= CSR_TOPIC_CHARS_0 && csr_index <= CSR_TOPIC_CHARS_5) begin
               topic_word[csr_index - CSR_TOPIC_CHARS_0] = csr_data;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               report("no verdict expected", '0, rsp_payload);
            end else begin
               want = verdict_queue.pop_front();
               verdicts++;
               if (want.packet_accepted) accepted++;
               if (want.event_code != EVENT_NONE) events++;
               if (rsp_payload.event_code !== want.event_code ||
                   rsp_payload.exit_seen !== want.exit_seen ||
                   rsp_payload.packet_accepted !== want.packet_accepted) begin
                  report("field mismatch", want, rsp_payload);
               end
            end
         end
         if (req_valid && !req_stall) begin
            parse_packet_byte(req_payload.packet_byte, req_payload.final_byte);
         end
      end
      mismatch_count <= errors;
      pending_count  <= verdict_queue.size();
      verdict_count  <= verdicts;
      accepted_count <= accepted;
      event_count    <= events;
   end

endmodule

// File: tb/sv/tb_publish_packet_topic_keyword_filter.sv
// Testbench top for the PUBLISH topic filter: packet stimulus, handshakes, watchdog and verdict.
`timescale 1ns / 100ps
module tb_publish_packet_topic_keyword_filter
   import pptkf_pkg::*;
();

   localparam int         ITEMS      = 1450;
   localparam int         PHASES     = 8;
   localparam int         IDLE_LIMIT = 1000;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   int mismatch_count;
   int pending_count;
   int verdict_count;
   int accepted_count;
   int event_count;

   // Stimulus bookkeeping and the topic currently programmed.
   logic [7:0] frame [$];
   logic [7:0] topic_text [TOPIC_MAX];
   int         topic_want    = 0;
   logic       quiet         = 1'b0;
   int         bytes_sent    = 0;
   int         packets_sent  = 0;
   int         settings_used = 1;
   int         idle_cycles   = 0;
   logic       moved;

   publish_packet_topic_keyword_filter uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   publish_filter_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count),
      .verdict_count (verdict_count),
      .accepted_count(accepted_count),
      .event_count   (event_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Quoted keywords that the payload search looks for.
   function automatic string keyword(int k);
      case (k)
         0:       return "\"result\":\"win\"";
         1:       return "\"result\":\"lose\"";
         2:       return "\"result\":\"reset\"";
         3:       return "\"result\":\"exit\"";
         4:       return "\"status\":\"offline\"";
         default: return "\"status\":\"disconnect\"";
      endcase
   endfunction

   // Offer one byte after a random gap and hold it until the block takes it.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{packet_byte: b, final_byte: last};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
      packets_sent++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
   endtask

   task automatic push_printable(int n);
      repeat (n) frame.push_back(8'($urandom_range(32, 126)));
   endtask

   // Payload built from keywords, near misses, noise, zero bytes and the odd long filler.
   task automatic push_payload();
      int         pieces;
      int         pick;
      int         spot;
      string      kw;
      logic [7:0] c;
      logic [7:0] mask;
      pieces = $urandom_range(0, 3);
      repeat (pieces) begin
         pick = $urandom_range(0, 9);
         if (pick <= 4) begin
            push_text(keyword($urandom_range(0, 5)));
         end else if (pick == 5) begin
            kw   = keyword($urandom_range(0, 5));
            spot = $urandom_range(0, kw.len() - 1);
            mask = 8'($urandom_range(1, 255));
            for (int i = 0; i < kw.len(); i++) begin
               c = kw[i];
               frame.push_back(i == spot ? c ^ mask : c);
            end
         end else if (pick == 6) begin
            repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(1, 255)));
         end else if (pick == 7) begin
            frame.push_back(8'h00);
         end else if (pick == 9 && $urandom_range(0, 3) == 0) begin
            push_printable($urandom_range(140, 175));
         end else begin
            push_printable($urandom_range(1, 6));
         end
      end
   endtask

   // One packet: mostly well formed with a matching topic, the rest broken in some way.
   task automatic send_random_packet();
      int         kind;
      int         conts;
      int         rx_len;
      int         start;
      int         spot;
      logic [7:0] hdr;
      logic [7:0] hi;
      logic [7:0] lo;
      frame.delete();
      quiet = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 11);

      // Fixed header with a type nibble that is PUBLISH unless a wrong one is wanted.
      hdr = {PUBLISH_TYPE, 4'($urandom_range(0, 15))};
      if (kind == 8) begin
         while (hdr[7:4] == PUBLISH_TYPE) hdr = 8'($urandom_range(0, 255));
      end
      frame.push_back(hdr);

      // Remaining-length field, now and then with a long run of continuation bytes.
      conts = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 2);
      repeat (conts) frame.push_back(8'($urandom_range(128, 255)));
      frame.push_back(8'($urandom_range(0, 127)));

      // An oversized topic length rejects the packet whatever follows.
      if (kind == 9) begin
         hi = 8'($urandom_range(0, 255));
         lo = (hi == 8'h00) ? 8'($urandom_range(TOPIC_BUFFER, 255)) : 8'($urandom_range(0, 255));
         frame.push_back(hi);
         frame.push_back(lo);
         repeat ($urandom_range(0, 6)) frame.push_back(8'($urandom_range(0, 255)));
         send_frame();
         return;
      end

      // Topic length: exact, padded after a zero byte, or one off.
      rx_len = topic_want;
      if (kind == 10 && (topic_want == 0 || $urandom_range(0, 1) == 0)) begin
         rx_len = (topic_want > 0 && $urandom_range(0, 1) == 0) ? topic_want - 1 : topic_want + 1;
      end else if (kind <= 7 && $urandom_range(0, 3) == 0) begin
         rx_len = $urandom_range(topic_want + 1, TOPIC_BUFFER - 1);
      end
      frame.push_back(8'(rx_len >> 8));
      frame.push_back(8'(rx_len));
      start = frame.size();
      for (int i = 0; i < rx_len; i++) begin
         if (i < topic_want) frame.push_back(topic_text[i]);
         else if (i == topic_want && kind != 10) frame.push_back(8'h00);
         else frame.push_back(8'($urandom_range(1, 255)));
      end

      // Corrupt one topic byte when the length was kept.
      if (kind == 10 && rx_len == topic_want && topic_want > 0) begin
         spot = start + $urandom_range(0, topic_want - 1);
         frame[spot] = frame[spot] ^ 8'($urandom_range(1, 255));
      end

      push_payload();

      // Cut the packet short somewhere.
      if (kind == 11 && frame.size() > 1) begin
         frame = frame[0:$urandom_range(0, frame.size() - 2)];
      end
      send_frame();
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Wait for the block to drain, then write every topic register.
   task automatic program_topic(input logic [5:0] len, input logic junk);
      logic [63:0] word;
      logic [63:0] filler;
      int          lim;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (3) @(posedge clock);
      filler = {$urandom, $urandom};
      csr_write(CSR_TOPIC_LENGTH, {filler[63:6], len});
      for (int k = 0; k < TOPIC_REGS; k++) begin
         for (int j = 0; j < 8; j++) word[8 * j +: 8] = topic_text[8 * k + j];
         csr_write(3'(CSR_TOPIC_CHARS_0 + k), word);
      end
      if (junk) csr_write(CSR_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;

      // The topic that packets must carry: capped length, cut at a zero byte.
      lim        = (len > TOPIC_MAX) ? TOPIC_MAX : int'(len);
      topic_want = lim;
      for (int i = lim - 1; i >= 0; i--) begin
         if (topic_text[i] == 8'h00) topic_want = i;
      end
      settings_used++;
   endtask

   // Topic settings per phase: longest, over the cap, empty, cut by a zero, random, all zero.
   task automatic choose_topic(input int ph);
      logic [5:0] len;
      for (int i = 0; i < TOPIC_MAX; i++) topic_text[i] = 8'($urandom_range(33, 126));
      case (ph)
         1: len = 6'(TOPIC_MAX);
         2: begin
            len = 6'd63;
            for (int i = 0; i < TOPIC_MAX; i++) topic_text[i] = 8'hFF;
         end
         3: len = 6'd0;
         4: begin
            len           = 6'd12;
            topic_text[5] = 8'h00;
         end
         7: begin
            len = 6'(TOPIC_MAX);
            for (int i = 0; i < TOPIC_MAX; i++) topic_text[i] = 8'h00;
         end
         default: begin
            len = 6'($urandom_range(0, 63));
            for (int i = 0; i < TOPIC_MAX; i++) begin
               topic_text[i] = ($urandom_range(0, 39) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            end
         end
      endcase
      program_topic(len, ph == 2 || ph == 7);
   endtask

   // Result side: stretches without stalls, otherwise a random hold on every verdict.
   initial begin
      int   hold;
      logic rx_quiet;
      rx_quiet = 1'b0;
      forever begin
         if ($urandom_range(0, 9) == 0) rx_quiet = !rx_quiet;
         hold = rx_quiet ? 0 : $urandom_range(0, 19);
         if (hold == 0) begin
            rsp_stall <= 1'b0;
            do @(posedge clock); while (rsp_valid !== 1'b1);
         end else begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (rsp_valid !== 1'b1);
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Watchdog: too long without any transaction on any channel ends the run.
   assign moved = (req_valid === 1'b1 && req_stall === 1'b0) ||
                  (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
                  (csr_valid === 1'b1 && csr_ready === 1'b1);

   always @(posedge clock) begin
      if (reset || moved) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Main sequence: reset, short directed packets, then random packets over several topics.
   initial begin
      int budget;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed packets against the empty topic left by reset.
      frame = '{8'h30};
      send_frame();
      frame = '{8'h30, 8'h00, 8'h00, 8'h00};
      send_frame();
      frame = '{8'h30, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      frame = '{8'h2F, 8'h00, 8'h00, 8'h00, 8'h41};
      send_frame();
      frame = '{8'h3F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h41};
      send_frame();
      frame = '{8'h30, 8'h05, 8'h00, 8'h40, 8'h41, 8'h42};
      send_frame();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) choose_topic(ph);
         budget = bytes_sent + ITEMS / PHASES;
         while (bytes_sent < budget) send_random_packet();
      end

      // Drain the last verdicts and let the block settle.
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);

      $display("Sent %0d bytes in %0d packets under %0d topic settings.",
               bytes_sent, packets_sent, settings_used);
      $display("Checked %0d verdicts: %0d packets accepted, %0d with a keyword event.",
               verdict_count, accepted_count, event_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/pptkf_pkg.sv
rtl/pptkf_window_cell.sv
rtl/publish_packet_topic_keyword_filter.sv
tb/sv/publish_filter_checker.sv
tb/sv/tb_publish_packet_topic_keyword_filter.sv
